// ----- rtl/positional_list_store_top_defines.svh -----
// Assertion macros for the RTL; pls_ctrl.sv includes them.
`ifndef POSITIONAL_LIST_STORE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_STORE_TOP_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define PLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define PLS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/pls_pkg.sv -----
package pls_pkg;

  // Storage geometry
  localparam int Capacity = 16;
  localparam int DataW    = 32;

  // Fixed field widths
  localparam int PosW = 5;
  localparam int ValW = 32;
  localparam int LenW = 5;

  // Derived widths
  localparam int CntW  = $clog2(Capacity + 1);
  localparam int AddrW = $clog2(Capacity);
  localparam int CmpW  = ((PosW > CntW) ? PosW : CntW) + 1;

  typedef enum logic [1:0] {
    ReqInsert = 2'd0,
    ReqDelete = 2'd1,
    ReqRead   = 2'd2,
    ReqWrite  = 2'd3
  } req_e;

  // Store port request from the sequencer
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

  // One result transaction
  typedef struct packed {
    logic            status;
    logic [ValW-1:0] read_value;
    logic [LenW-1:0] length;
  } result_t;

  // Keep the low DataW bits (sign-extended when DataW is wider)
  function automatic logic [DataW-1:0] to_store(input logic signed [ValW-1:0] v);
    return DataW'(v);
  endfunction

  // Sign-extend a stored word back to the result width
  function automatic logic [ValW-1:0] from_store(input logic [DataW-1:0] w);
    logic signed [DataW-1:0] s;
    s = w;
    return ValW'(s);
  endfunction

endpackage

// ----- rtl/pls_ram.sv -----
module pls_ram #(
  parameter int Depth = 16,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pls_ctrl.sv -----
`include "positional_list_store_top_defines.svh"

module pls_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  output logic                      req_ready_o,
  input  logic [1:0]                req_type_i,
  input  logic [pls_pkg::PosW-1:0]  pos_i,
  input  logic [pls_pkg::ValW-1:0]  val_i,
  input  logic                      res_free_i,
  output logic                      res_load_o,
  output pls_pkg::result_t          res_o,
  output pls_pkg::ram_req_t         ram_o,
  input  logic [pls_pkg::DataW-1:0] ram_rdata_i
);

  localparam int CmpW  = pls_pkg::CmpW;
  localparam int CntW  = pls_pkg::CntW;
  localparam int AddrW = pls_pkg::AddrW;

  typedef enum logic [8:0] {
    StIdle    = 9'b000000001,
    StCheck   = 9'b000000010,
    StUpRd    = 9'b000000100,
    StUpWr    = 9'b000001000,
    StInsWr   = 9'b000010000,
    StGetWait = 9'b000100000,
    StDnRd    = 9'b001000000,
    StDnWr    = 9'b010000000,
    StFinish  = 9'b100000000
  } state_e;

  state_e                     state_q, state_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [CntW-1:0]            k_q, k_d;
  logic                       err_q, err_d;
  logic [pls_pkg::ValW-1:0]   rd_q, rd_d;
  pls_pkg::req_e              req_q;
  logic [pls_pkg::PosW-1:0]   pos_q;
  logic [pls_pkg::ValW-1:0]   val_q;

  logic [CmpW-1:0] pos_x, cnt_x, k_x, pos_m1, k_m1, k_p1;
  logic            err_now;
  logic            accept;

  // Shared index arithmetic and compares
  assign pos_x  = CmpW'(pos_q);
  assign cnt_x  = CmpW'(cnt_q);
  assign k_x    = CmpW'(k_q);
  assign pos_m1 = pos_x - CmpW'(1);
  assign k_m1   = k_x - CmpW'(1);
  assign k_p1   = k_x + CmpW'(1);

  always_comb begin
    if (req_q == pls_pkg::ReqInsert) begin
      err_now = (pos_x == '0) || (pos_x > cnt_x + CmpW'(1)) ||
                (cnt_x >= CmpW'(pls_pkg::Capacity));
    end else begin
      err_now = (pos_x == '0) || (pos_x > cnt_x);
    end
  end

  assign req_ready_o = (state_q == StIdle);
  assign accept      = req_valid_i && req_ready_o;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    err_d       = err_q;
    rd_d        = rd_q;
    res_load_o  = 1'b0;
    ram_o.we    = 1'b0;
    ram_o.waddr = pos_m1[AddrW-1:0];
    ram_o.wdata = pls_pkg::to_store(val_q);
    ram_o.raddr = pos_m1[AddrW-1:0];
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        rd_d  = '0;
        err_d = err_now;
        if (err_now) begin
          state_d = StFinish;
        end else begin
          case (req_q)
            pls_pkg::ReqInsert: begin
              k_d = cnt_q;
              state_d = (cnt_x >= pos_x) ? StUpRd : StInsWr;
            end
            pls_pkg::ReqWrite: begin
              ram_o.we = 1'b1;
              state_d  = StFinish;
            end
            default: begin
              // delete and read: entry at pos-1 is read this cycle
              k_d     = pos_x[CntW-1:0];
              state_d = StGetWait;
            end
          endcase
        end
      end
      StUpRd: begin
        ram_o.raddr = k_m1[AddrW-1:0];
        state_d     = StUpWr;
      end
      StUpWr: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = k_x[AddrW-1:0];
        ram_o.wdata = ram_rdata_i;
        k_d         = k_m1[CntW-1:0];
        state_d     = (k_x > pos_x) ? StUpRd : StInsWr;
      end
      StInsWr: begin
        ram_o.we = 1'b1;
        cnt_d    = cnt_q + CntW'(1);
        state_d  = StFinish;
      end
      StGetWait: begin
        rd_d = pls_pkg::from_store(ram_rdata_i);
        if (req_q == pls_pkg::ReqDelete) begin
          if (k_x < cnt_x) begin
            state_d = StDnRd;
          end else begin
            cnt_d   = cnt_q - CntW'(1);
            state_d = StFinish;
          end
        end else begin
          state_d = StFinish;
        end
      end
      StDnRd: begin
        ram_o.raddr = k_x[AddrW-1:0];
        state_d     = StDnWr;
      end
      StDnWr: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = k_m1[AddrW-1:0];
        ram_o.wdata = ram_rdata_i;
        k_d         = k_p1[CntW-1:0];
        if (k_p1 < cnt_x) begin
          state_d = StDnRd;
        end else begin
          cnt_d   = cnt_q - CntW'(1);
          state_d = StFinish;
        end
      end
      StFinish: begin
        res_load_o = res_free_i;
        if (res_free_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Working registers, no reset
  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    err_q <= err_d;
    rd_q  <= rd_d;
    if (accept) begin
      req_q <= pls_pkg::req_e'(req_type_i);
      pos_q <= pos_i;
      val_q <= val_i;
    end
  end

  assign res_o.status     = err_q;
  assign res_o.read_value = rd_q;
  assign res_o.length     = pls_pkg::LenW'(cnt_q);

  `PLS_ASSERT(a_cnt_bound, cnt_q <= CntW'(pls_pkg::Capacity), "element count above capacity")
  `PLS_ASSERT_NEVER(a_idle_no_write, (state_q == StIdle) && ram_o.we, "store written while idle")
  `PLS_ASSERT(a_cnt_step, (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CntW'(1)) || (cnt_q == $past(cnt_q) - CntW'(1)), "count moved by more than one")
  `PLS_ASSERT(a_err_zero, (res_load_o && res_o.status) |-> (res_o.read_value == '0), "error result carries data")

endmodule

// ----- rtl/positional_list_store_top.sv -----
// Channel   Dir  tdata (low bit up)                          tuser
// s_axis    in   position[4:0], new_value[36:5], zero[39:37]  req_type[1:0]
// m_axis    out  read_value[31:0], length[36:32], zero[39:37] status[0]
//
// One request at a time; tready on s_axis is high only while idle.
// Insert and delete shift entries one at a time through the store, with a read state and then
// a write state per entry moved (up to 15 entries moved).
// The result sits in an output register, so a new request is taken while it waits.
// rst_ni is asynchronous, active low, and empties the list; store words need no clearing.
// A stalled m_axis holds the sequencer in its final state until the slot frees.
module positional_list_store_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // position[4:0], new_value[36:5], zero pad
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // read_value[31:0], length[36:32], zero pad
  output logic [0:0]  m_axis_tuser   // status[0]
);

  pls_pkg::ram_req_t          ram_req;
  logic [pls_pkg::DataW-1:0]  ram_rdata;
  pls_pkg::result_t           res;
  logic                       res_load;
  logic                       res_free;
  logic                       out_valid_q;
  pls_pkg::result_t           out_q;

  assign res_free = !out_valid_q || m_axis_tready;

  pls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .pos_i       (s_axis_tdata[4:0]),
    .val_i       (s_axis_tdata[36:5]),
    .res_free_i  (res_free),
    .res_load_o  (res_load),
    .res_o       (res),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  pls_ram #(
    .Depth (pls_pkg::Capacity),
    .Width (pls_pkg::DataW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.length, out_q.read_value};
  assign m_axis_tuser  = out_q.status;

endmodule
